>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker module srd_checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SRD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srd: assertion failed");

// Expression must never be true at a clock edge outside reset.
`define SRD_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("srd: forbidden condition seen");

`endif

>>> rtl/core/srd_pkg.sv
`timescale 1ns / 1ps
// Package for the scanline downscaler: sizes, register and mode codes,
// pixel helper functions. No dependencies.
package srd_pkg;

  localparam int HALF_WIDTH  = 128;
  localparam int HALF_HEIGHT = 120;
  localparam int ADDR_W      = $clog2(HALF_WIDTH);

  localparam int PIX_W   = 16;
  localparam int RGB_W   = 15;
  localparam int LINE_W  = 8;
  localparam int PAIR_W  = 7;
  localparam int COORD_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLACE_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SELECT     = 2'd2;

  localparam logic [1:0] MODE_BOX     = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_FULL    = 2'd2;

  localparam logic [RGB_W-1:0] RGB_MASK   = 15'h7FFF;
  localparam logic [RGB_W-1:0] CARRY_BITS = 15'h0421;
  localparam logic [RGB_W-1:0] RG_MASK    = 15'h7FE0;
  localparam logic [RGB_W-1:0] BLUE_MASK  = 15'h001F;

  typedef enum logic [1:0] {
    KIND_BOX,
    KIND_NEAREST,
    KIND_FULL
  } srd_kind_e;

  function automatic logic [RGB_W-1:0] srd_mean555(input logic [RGB_W-1:0] a,
                                                   input logic [RGB_W-1:0] b);
    logic [RGB_W:0] sum;
    sum = {1'b0, a & RGB_MASK} + {1'b0, b & RGB_MASK} - {1'b0, (a ^ b) & CARRY_BITS};
    return sum[RGB_W:1];
  endfunction

  function automatic logic [PIX_W-1:0] srd_to565(input logic [RGB_W-1:0] v);
    logic [RGB_W-1:0] rg;
    logic [RGB_W-1:0] bl;
    rg = v & RG_MASK;
    bl = v & BLUE_MASK;
    return {rg, 1'b0} | {1'b0, bl};
  endfunction

endpackage

>>> rtl/core/srd_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the scanline downscaler: pixel pair input,
// RGB565 result output and register write port. Depends on srd_pkg.
interface srd_pix_in_if;
  import srd_pkg::*;
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_left;
  logic [PIX_W-1:0]  pixel_right;
  logic [LINE_W-1:0] line_number;
  logic [PAIR_W-1:0] pair_index;

  modport source (output valid, pixel_left, pixel_right, line_number, pair_index,
                  input ready);
  modport sink   (input valid, pixel_left, pixel_right, line_number, pair_index,
                  output ready);
endinterface

interface srd_pix_out_if;
  import srd_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_out;
  logic [LINE_W-1:0]  out_row;
  logic [COORD_W-1:0] out_col;
  logic               last_of_item;

  modport source (output valid, pixel_out, out_row, out_col, last_of_item,
                  input ready);
  modport sink   (input valid, pixel_out, out_row, out_col, last_of_item,
                  output ready);
endinterface

interface srd_cfg_if;
  import srd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/scanline_rgb555_downscaler_core.sv
`timescale 1ns / 1ps
// Scanline RGB555 to RGB565 downscaler, three-stage pipeline with row store.
// Depends on srd_pkg and the interfaces in srd_if.sv.
//
// Usage:
//   pix_i carries one pair of adjacent source pixels per transaction, with
//   its line and pair index. pix_o carries RGB565 result pixels with their
//   destination row and column; last_of_item marks the final one of a pair.
//   cfg_i writes scale_mode (0), interlace_enable (1), field_select (2); it is
//   always ready; write it only while the pipeline is empty (not enforced).
// Timing:
//   One pair enters per cycle while pix_i.ready is high. Stage 1 reads the
//   even-row store and forms the horizontal average, stage 2 forms the
//   vertical average and the RGB565 pixels, stage 3 holds the results for
//   pix_o. A pair passes the stage 1, 2 and 3 registers before its result
//   is valid on pix_o. Full-resolution mode gives two results per pair, one
//   per cycle from stage 3 while pix_o.ready is high, and stage 3 takes no
//   new pair until the second result is taken.
// Reset:
//   Clears all stages, the store valid bits (the store reads as zero) and
//   loads scale_mode 2, interlace_enable 1, field_select 0.
// Stall:
//   When pix_o.ready is low, stage 3 holds; earlier stages keep filling
//   bubbles and pix_i.ready drops once all three stages are full.
module scanline_rgb555_downscaler_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  srd_pix_in_if.sink          pix_i,
  srd_pix_out_if.source       pix_o,
  srd_cfg_if.sink             cfg_i
);
  import srd_pkg::*;

  logic [1:0] mode_q;
  logic       ilace_q;
  logic       fsel_q;

  logic [RGB_W-1:0] store_mem [HALF_WIDTH];
  logic [HALF_WIDTH-1:0] store_vld_q;

  logic              v1_q;
  logic [PIX_W-1:0]  s1_left_q;
  logic [PIX_W-1:0]  s1_right_q;
  logic [LINE_W-1:0] s1_line_q;
  logic [PAIR_W-1:0] s1_pair_q;
  logic [RGB_W-1:0]  s1_rd_data_q;
  logic              s1_rd_vld_q;
  logic              s1_fwd_q;
  logic [RGB_W-1:0]  s1_fwd_data_q;

  logic               v2_q;
  srd_kind_e          s2_kind_q;
  logic [RGB_W-1:0]   s2_h_q;
  logic [RGB_W-1:0]   s2_above_q;
  logic [RGB_W-1:0]   s2_left_q;
  logic [RGB_W-1:0]   s2_right_q;
  logic [LINE_W-1:0]  s2_row_q;
  logic [COORD_W-1:0] s2_col_q;

  logic               v3_q;
  logic [PIX_W-1:0]   s3_pix_a_q;
  logic [PIX_W-1:0]   s3_pix_b_q;
  logic [LINE_W-1:0]  s3_row_q;
  logic [COORD_W-1:0] s3_col_q;
  logic               s3_two_q;
  logic               ph_q;

  logic rdy1, rdy2, rdy3;
  logic out_last;

  logic [RGB_W-1:0]   s1_h;
  logic [RGB_W-1:0]   s1_above;
  logic               s1_odd;
  logic               s1_pair_ok;
  logic               s1_row_ok;
  logic               s1_wr;
  logic               s1_emit;
  srd_kind_e          s1_kind;
  logic [LINE_W-1:0]  s1_row;
  logic [COORD_W-1:0] s1_col;
  logic               fwd_d;

  logic [PIX_W-1:0] s2_pix_a;
  logic [PIX_W-1:0] s2_pix_b;

  // Handshake chain
  assign out_last    = ph_q || !s3_two_q;
  assign rdy3        = !v3_q || (pix_o.ready && out_last);
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign pix_i.ready = rdy1;
  assign cfg_i.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FULL;
      ilace_q <= 1'b1;
      fsel_q  <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SCALE_MODE:       mode_q  <= cfg_i.data[1:0];
        REG_INTERLACE_ENABLE: ilace_q <= cfg_i.data[0];
        REG_FIELD_SELECT:     fsel_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Stage 1 decode
  always_comb begin
    s1_h       = srd_mean555(s1_left_q[RGB_W-1:0], s1_right_q[RGB_W-1:0]);
    s1_odd     = s1_line_q[0];
    s1_pair_ok = int'(s1_pair_q) < HALF_WIDTH;
    s1_row_ok  = int'(s1_line_q[LINE_W-1:1]) < HALF_HEIGHT;
    s1_above   = s1_fwd_q ? s1_fwd_data_q : (s1_rd_vld_q ? s1_rd_data_q : '0);
    s1_wr      = 1'b0;
    s1_emit    = 1'b0;
    s1_kind    = KIND_FULL;
    s1_row     = s1_line_q;
    s1_col     = {s1_pair_q, 1'b0};
    unique case (mode_q)
      MODE_BOX: begin
        s1_kind = KIND_BOX;
        s1_wr   = s1_pair_ok && !s1_odd;
        s1_emit = s1_pair_ok && s1_odd && s1_row_ok;
        s1_row  = {1'b0, s1_line_q[LINE_W-1:1]};
        s1_col  = {1'b0, s1_pair_q};
      end
      MODE_NEAREST: begin
        s1_kind = KIND_NEAREST;
        s1_emit = s1_pair_ok && !s1_odd && s1_row_ok;
        s1_row  = {1'b0, s1_line_q[LINE_W-1:1]};
        s1_col  = {1'b0, s1_pair_q};
      end
      MODE_FULL: begin
        s1_kind = KIND_FULL;
        s1_emit = s1_pair_ok && !(ilace_q && (s1_odd != fsel_q));
      end
      default: ;
    endcase
  end

  // Forward an even-line write that lands in the same cycle as the read
  assign fwd_d = v1_q && rdy2 && s1_wr && (s1_pair_q == pix_i.pair_index);

  // Row store, registered read
  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2 && s1_wr) begin
      store_mem[s1_pair_q[ADDR_W-1:0]] <= s1_h;
    end
    if (rdy1) begin
      s1_rd_data_q <= store_mem[pix_i.pair_index[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_vld_q <= '0;
      s1_rd_vld_q <= 1'b0;
    end else begin
      if (v1_q && rdy2 && s1_wr) begin
        store_vld_q[s1_pair_q[ADDR_W-1:0]] <= 1'b1;
      end
      if (rdy1) begin
        s1_rd_vld_q <= store_vld_q[pix_i.pair_index[ADDR_W-1:0]];
      end
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else if (rdy1) begin
      v1_q     <= pix_i.valid;
      s1_fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_left_q     <= pix_i.pixel_left;
      s1_right_q    <= pix_i.pixel_right;
      s1_line_q     <= pix_i.line_number;
      s1_pair_q     <= pix_i.pair_index;
      s1_fwd_data_q <= s1_h;
    end
  end

  // Stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q && s1_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_kind_q  <= s1_kind;
      s2_h_q     <= s1_h;
      s2_above_q <= s1_above;
      s2_left_q  <= s1_left_q[RGB_W-1:0];
      s2_right_q <= s1_right_q[RGB_W-1:0];
      s2_row_q   <= s1_row;
      s2_col_q   <= s1_col;
    end
  end

  // Stage 2 pixel formation
  always_comb begin
    s2_pix_b = srd_to565(s2_right_q);
    unique case (s2_kind_q)
      KIND_BOX:     s2_pix_a = srd_to565(srd_mean555(s2_above_q, s2_h_q));
      KIND_NEAREST: s2_pix_a = srd_to565(s2_left_q);
      KIND_FULL:    s2_pix_a = srd_to565(s2_left_q);
      default:      s2_pix_a = srd_to565(s2_left_q);
    endcase
  end

  // Stage 3 registers and result sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      ph_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (v3_q && pix_o.ready) begin
        ph_q <= !out_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_pix_a_q <= s2_pix_a;
      s3_pix_b_q <= s2_pix_b;
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_two_q   <= (s2_kind_q == KIND_FULL);
    end
  end

  assign pix_o.valid        = v3_q;
  assign pix_o.pixel_out    = ph_q ? s3_pix_b_q : s3_pix_a_q;
  assign pix_o.out_row      = s3_row_q;
  assign pix_o.out_col      = {s3_col_q[COORD_W-1:1], s3_col_q[0] | ph_q};
  assign pix_o.last_of_item = out_last;

endmodule

>>> rtl/core/srd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the scanline downscaler and its bind statement.
// Depends on assert_macros.svh and srd_pkg.
`include "assert_macros.svh"

module srd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [srd_pkg::PIX_W-1:0]    pixel_out_i,
  input logic [srd_pkg::LINE_W-1:0]   out_row_i,
  input logic [srd_pkg::COORD_W-1:0]  out_col_i,
  input logic                         last_i
);
  import srd_pkg::*;

  // Hold a stalled result transaction
  `SRD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(pixel_out_i) && $stable(out_row_i) && $stable(out_col_i) && $stable(last_i))

  // Advance to the right pixel of the same row after a non-final result
  `SRD_ASSERT(a_pair_follow, out_valid_i && out_ready_i && !last_i |=> out_valid_i && last_i && out_row_i == $past(out_row_i) && out_col_i == ($past(out_col_i) | 8'd1))

  // Non-final result is always the left pixel
  `SRD_ASSERT_NEVER(a_left_even, out_valid_i && !last_i && out_col_i[0])

  // Green low bit of an RGB565 result stays zero
  `SRD_ASSERT_NEVER(a_green_lsb, out_valid_i && pixel_out_i[5])

endmodule

bind scanline_rgb555_downscaler_core srd_checker u_srd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .pixel_out_i (pix_o.pixel_out),
  .out_row_i   (pix_o.out_row),
  .out_col_i   (pix_o.out_col),
  .last_i      (pix_o.last_of_item)
);
